// ----- rtl/core/hslc_pkg.sv -----
// shared types, constants and arithmetic helpers for the hsl colorize block
package hslc_pkg;

    localparam int HUE_W  = 13;
    localparam int SAT_W  = 11;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int Q_W    = 13;

    localparam logic [HUE_W-1:0] HUE_LIMIT  = 13'd5760;
    localparam logic [HUE_W-1:0] SECTOR_LEN = 13'd960;
    localparam logic [SAT_W-1:0] FULL_SAT   = 11'd1024;
    localparam logic [Q_W-1:0]   Q_MAX      = 13'd7650;
    localparam logic [13:0]      RECIP_30   = 14'd8739;

    typedef enum logic
    {
        REG_HUE = 1'b0,
        REG_SAT = 1'b1
    } reg_sel_t;

    typedef enum logic [2:0]
    {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYN = 3'd2,
        SECT_CYN_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed
    {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed
    {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } result_t;

    typedef struct packed
    {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
    } cfg_t;

    function automatic sector_t hue_sector(input logic [HUE_W-1:0] h);
        sector_t s;
        if (h >= 13'd4800)
            s = SECT_MAG_RED;
        else if (h >= 13'd3840)
            s = SECT_BLU_MAG;
        else if (h >= 13'd2880)
            s = SECT_CYN_BLU;
        else if (h >= 13'd1920)
            s = SECT_GRN_CYN;
        else if (h >= SECTOR_LEN)
            s = SECT_YEL_GRN;
        else
            s = SECT_RED_YEL;
        return s;
    endfunction

    // triangle weight of the hue within its pair of sectors, 0..960
    function automatic logic [9:0] hue_weight(input logic [HUE_W-1:0] h);
        logic [HUE_W-1:0] u;
        logic [HUE_W-1:0] w;
        if (h >= 13'd3840)
            u = h - 13'd3840;
        else if (h >= 13'd1920)
            u = h - 13'd1920;
        else
            u = h;
        w = (u >= SECTOR_LEN) ? (13'd1920 - u) : u;
        return w[9:0];
    endfunction

    // magnitude over 2^16, capped at 255*30
    function automatic logic [Q_W-1:0] scale_q(input logic [30:0] mag);
        logic [14:0] q;
        q = mag[30:16];
        return (q > 15'(Q_MAX)) ? Q_MAX : q[Q_W-1:0];
    endfunction

    // floor(q/30) by reciprocal multiply, exact for q below 7680
    function automatic logic [7:0] div30(input logic [Q_W-1:0] q);
        logic [26:0] prod;
        prod = 27'(q) * 27'(RECIP_30);
        return prod[25:18];
    endfunction

endpackage

// ----- rtl/core/hslc_pipe.sv -----
// six-stage colorize datapath: lightness, chroma, hue terms, scaling
module hslc_pipe
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  hslc_pkg::pixel_t pixel,
    input  hslc_pkg::cfg_t   cfg,
    output logic             out_valid,
    output hslc_pkg::result_t result
);

    logic [4:0] valid_reg;
    logic [4:0] valid_next;
    logic       done_reg;

    hslc_pkg::pixel_t pix0_reg;
    hslc_pkg::pixel_t pix1_reg;
    hslc_pkg::pixel_t pix2_reg;
    hslc_pkg::pixel_t pix3_reg;
    hslc_pkg::pixel_t pix4_reg;

    logic [8:0]  sum1_reg;
    logic [8:0]  sum1_next;
    logic [7:0]  a1_reg;
    logic [7:0]  a1_next;
    logic [8:0]  sum2_reg;
    logic [17:0] p2_reg;
    logic [17:0] p2_next;
    logic [27:0] pk3_reg;
    logic [27:0] pk3_next;
    logic [19:0] tc3_reg;
    logic [19:0] tc3_next;
    logic signed [19:0] t03_reg;
    logic signed [19:0] t03_next;
    logic [hslc_pkg::Q_W-1:0] qc4_reg;
    logic [hslc_pkg::Q_W-1:0] qx4_reg;
    logic [hslc_pkg::Q_W-1:0] q04_reg;
    logic [hslc_pkg::Q_W-1:0] qc4_next;
    logic [hslc_pkg::Q_W-1:0] qx4_next;
    logic [hslc_pkg::Q_W-1:0] q04_next;
    hslc_pkg::result_t res_reg;
    hslc_pkg::result_t res_next;

    logic [7:0] mx;
    logic [7:0] mn;
    logic [hslc_pkg::SAT_W-1:0] s_clamp;
    logic [9:0] k;
    logic [29:0] nc;
    logic signed [31:0] n0;
    logic signed [31:0] nx;
    logic [31:0] mag0;
    logic [31:0] magx;
    logic [7:0] dc;
    logic [7:0] dx;
    logic [7:0] d0;

    assign valid_next = {valid_reg[3:0], in_valid};

    // stage 1: max, min, lightness sum and distance from the extremes
    always_comb
    begin
        mx = (pix0_reg.red_in > pix0_reg.green_in) ? pix0_reg.red_in : pix0_reg.green_in;
        mx = (mx > pix0_reg.blue_in) ? mx : pix0_reg.blue_in;
        mn = (pix0_reg.red_in < pix0_reg.green_in) ? pix0_reg.red_in : pix0_reg.green_in;
        mn = (mn < pix0_reg.blue_in) ? mn : pix0_reg.blue_in;
        sum1_next = 9'(mx) + 9'(mn);
        a1_next = (sum1_next >= 9'd255) ? 8'(9'd510 - sum1_next) : sum1_next[7:0];
    end

    // stage 2: chroma product
    always_comb
    begin
        s_clamp = (cfg.sat > hslc_pkg::FULL_SAT) ? hslc_pkg::FULL_SAT : cfg.sat;
        p2_next = 18'(a1_reg) * 18'(s_clamp);
    end

    // stage 3: hue weight product and the two lightness offsets
    always_comb
    begin
        k = hslc_pkg::hue_weight(cfg.hue);
        pk3_next = 28'(p2_reg) * 28'(k);
        tc3_next = {1'b0, sum2_reg, 10'b0} + {2'b0, p2_reg};
        t03_next = signed'({1'b0, sum2_reg, 10'b0}) - signed'({2'b0, p2_reg});
    end

    // stage 4: full numerators, magnitude and coarse scale
    always_comb
    begin
        nc = 30'(tc3_reg) * 30'd960;
        n0 = 32'(t03_reg) * 32'sd960;
        nx = n0 + signed'({3'b0, pk3_reg, 1'b0});
        mag0 = n0[31] ? 32'(-n0) : 32'(n0);
        magx = nx[31] ? 32'(-nx) : 32'(nx);
        qc4_next = hslc_pkg::scale_q({1'b0, nc});
        qx4_next = hslc_pkg::scale_q(magx[30:0]);
        q04_next = hslc_pkg::scale_q(mag0[30:0]);
    end

    // stage 5: final divide and sector permutation, or pass-through at or above the hue limit
    always_comb
    begin
        dc = hslc_pkg::div30(qc4_reg);
        dx = hslc_pkg::div30(qx4_reg);
        d0 = hslc_pkg::div30(q04_reg);
        if (cfg.hue >= hslc_pkg::HUE_LIMIT)
        begin
            res_next.red_out   = pix4_reg.red_in;
            res_next.green_out = pix4_reg.green_in;
            res_next.blue_out  = pix4_reg.blue_in;
        end
        else
        begin
            unique case (hslc_pkg::hue_sector(cfg.hue))
                hslc_pkg::SECT_RED_YEL:
                begin
                    res_next = '{red_out: dc, green_out: dx, blue_out: d0};
                end
                hslc_pkg::SECT_YEL_GRN:
                begin
                    res_next = '{red_out: dx, green_out: dc, blue_out: d0};
                end
                hslc_pkg::SECT_GRN_CYN:
                begin
                    res_next = '{red_out: d0, green_out: dc, blue_out: dx};
                end
                hslc_pkg::SECT_CYN_BLU:
                begin
                    res_next = '{red_out: d0, green_out: dx, blue_out: dc};
                end
                hslc_pkg::SECT_BLU_MAG:
                begin
                    res_next = '{red_out: dx, green_out: d0, blue_out: dc};
                end
                default:
                begin
                    res_next = '{red_out: dc, green_out: d0, blue_out: dx};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= valid_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        pix0_reg <= pixel;
        pix1_reg <= pix0_reg;
        pix2_reg <= pix1_reg;
        pix3_reg <= pix2_reg;
        pix4_reg <= pix3_reg;
        sum1_reg <= sum1_next;
        a1_reg   <= a1_next;
        sum2_reg <= sum1_reg;
        p2_reg   <= p2_next;
        pk3_reg  <= pk3_next;
        tc3_reg  <= tc3_next;
        t03_reg  <= t03_next;
        qc4_reg  <= qc4_next;
        qx4_reg  <= qx4_next;
        q04_reg  <= q04_next;
        res_reg  <= res_next;
    end

    assign out_valid = done_reg;
    assign result    = res_reg;

`ifndef NO_ASSERTIONS
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##6 out_valid)
        else $error("transaction did not complete after six cycles");

    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, 6))
        else $error("result without a matching transaction");

    // hue weight is only meaningful below the pass-through limit
    a_chroma_order: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[4] && (cfg.hue < hslc_pkg::HUE_LIMIT))
            |-> (qc4_reg >= qx4_reg) && (qc4_reg >= q04_reg))
        else $error("chroma channel below the other channels");
`endif

endmodule

// ----- rtl/core/hsl_colorize_pixel.sv -----
// top level of the hsl colorize block: register port and pixel datapath
//
// Recolors an RGB pixel stream with one programmed hue and saturation while
// keeping each pixel's HSL lightness. A pixel is taken on every clock in which
// start is high; busy is always low, so a new transaction may follow every
// cycle. Each result appears on result with done high for exactly one cycle,
// in order; the receiver cannot stall, so it must take every result when
// done is high. Each transaction passes through the six register stages of
// the datapath (input register, lightness, chroma multiply, hue multiply,
// numerator and scaling, divide by 30 and permutation into the output
// register). Hue at 360 degrees or above passes pixels through unchanged.
// Program the registers only while no transaction is in flight.
module hsl_colorize_pixel
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  hslc_pkg::pixel_t            pixel,
    output logic                        done,
    output hslc_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hslc_pkg::ADDR_W-1:0] paddr,
    input  logic [hslc_pkg::DATA_W-1:0] pwdata,
    output logic [hslc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    logic [hslc_pkg::HUE_W-1:0] hue_reg;
    logic [hslc_pkg::HUE_W-1:0] hue_next;
    logic [hslc_pkg::SAT_W-1:0] sat_reg;
    logic [hslc_pkg::SAT_W-1:0] sat_next;
    logic                       wr_en;
    hslc_pkg::reg_sel_t         sel;
    hslc_pkg::cfg_t             cfg;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign sel    = hslc_pkg::reg_sel_t'(paddr[2]);

    always_comb
    begin
        hue_next = hue_reg;
        sat_next = sat_reg;
        if (wr_en)
        begin
            unique case (sel)
                hslc_pkg::REG_HUE: hue_next = pwdata[hslc_pkg::HUE_W-1:0];
                hslc_pkg::REG_SAT: sat_next = pwdata[hslc_pkg::SAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            hslc_pkg::REG_HUE: prdata = hslc_pkg::DATA_W'(hue_reg);
            hslc_pkg::REG_SAT: prdata = hslc_pkg::DATA_W'(sat_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg <= '0;
            sat_reg <= '0;
        end
        else
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
        end
    end

    assign cfg.hue = hue_reg;
    assign cfg.sat = sat_reg;

    hslc_pipe u_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .pixel     (pixel),
        .cfg       (cfg),
        .out_valid (done),
        .result    (result)
    );

endmodule

// ----- tb/sv/hsl_colorize_pixel_tb.sv -----
// self-checking testbench for the hsl colorize pixel block
module hsl_colorize_pixel_tb;
    import hslc_pkg::*;

    localparam longint L_UNIT   = 983040;
    localparam longint OUT_UNIT = 1966080;
    localparam int     PHASES   = 17;
    localparam int     PLANNED  = 13;
    localparam int     PER_PHASE = 30;
    localparam int     CYCLE_LIMIT = 200000;

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    pixel_t              pixel   = '0;
    logic                done;
    result_t             result;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    pixel_t              pending_pixels[$];
    result_t             expected_colors[$];
    logic [HUE_W-1:0]    hue_setting = '0;
    logic [SAT_W-1:0]    sat_setting = '0;
    int                  gap_left = 0;
    bit                  burst_mode = 1'b0;
    int                  pixels_queued = 0;
    int                  colors_seen = 0;
    int                  error_count = 0;
    int                  cycle_count = 0;
    result_t             want;
    logic                next_start;
    pixel_t              next_pixel;

    int unsigned hue_plan [0:PLANNED-1] =
        '{0, 0, 480, 960, 1500, 1920, 3000, 3840, 4800, 5759, 5760, 8191, 5000};
    int unsigned sat_plan [0:PLANNED-1] =
        '{0, 1024, 1024, 2047, 600, 1024, 1, 1023, 1024, 1024, 512, 2047, 1025};

    hsl_colorize_pixel dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .pixel   (pixel),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] level_of(input longint v);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q = mag / OUT_UNIT;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic result_t colorize(input pixel_t px, input logic [HUE_W-1:0] hue,
                                         input logic [SAT_W-1:0] sat);
        result_t res;
        int      hi;
        int      lo;
        int      sum;
        int      span;
        int      s;
        int      h;
        int      u;
        int      k;
        longint  c;
        longint  x;
        longint  base;
        longint  vr;
        longint  vg;
        longint  vb;
        if (hue >= HUE_LIMIT)
        begin
            res.red_out   = px.red_in;
            res.green_out = px.green_in;
            res.blue_out  = px.blue_in;
            return res;
        end
        hi = px.red_in;
        lo = px.red_in;
        if (px.green_in > hi) hi = px.green_in;
        if (px.blue_in > hi) hi = px.blue_in;
        if (px.green_in < lo) lo = px.green_in;
        if (px.blue_in < lo) lo = px.blue_in;
        sum  = hi + lo;
        span = (sum >= 255) ? 510 - sum : sum;
        s    = (sat > FULL_SAT) ? int'(FULL_SAT) : int'(sat);
        h    = hue;
        u    = h % 1920;
        k    = (u >= 960) ? 1920 - u : u;
        c    = longint'(span) * s * 1920;
        x    = longint'(span) * s * k * 2;
        base = longint'(sum) * L_UNIT - longint'(span) * s * 960;
        case (sector_t'(h / 960))
            SECT_RED_YEL: begin vr = c; vg = x; vb = 0; end
            SECT_YEL_GRN: begin vr = x; vg = c; vb = 0; end
            SECT_GRN_CYN: begin vr = 0; vg = c; vb = x; end
            SECT_CYN_BLU: begin vr = 0; vg = x; vb = c; end
            SECT_BLU_MAG: begin vr = x; vg = 0; vb = c; end
            default:      begin vr = c; vg = 0; vb = x; end
        endcase
        res.red_out   = level_of(vr + base);
        res.green_out = level_of(vg + base);
        res.blue_out  = level_of(vb + base);
        return res;
    endfunction

    function automatic logic [7:0] rand_channel();
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
        return 8'($urandom);
    endfunction

    task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_t px;
        px.red_in   = r;
        px.green_in = g;
        px.blue_in  = b;
        pending_pixels.push_back(px);
        pixels_queued++;
    endtask

    task automatic write_reg(input reg_sel_t sel, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_HUE)
            hue_setting = value[HUE_W-1:0];
        else
            sat_setting = value[SAT_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // driver: one pixel transaction at a time from the pending queue
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            next_start = start;
            next_pixel = pixel;
            if (start && !busy)
            begin
                expected_colors.push_back(colorize(pixel, hue_setting, sat_setting));
                next_start = 1'b0;
                gap_left = burst_mode ? 0 : $urandom_range(0, 6);
            end
            if (!next_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_pixels.size() > 0)
                begin
                    next_pixel = pending_pixels.pop_front();
                    next_start = 1'b1;
                end
            end
            start <= next_start;
            pixel <= next_pixel;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            colors_seen++;
            if (expected_colors.size() == 0)
            begin
                $error("result with no transaction outstanding");
                error_count++;
            end
            else
            begin
                want = expected_colors.pop_front();
                check_field("red_out", want.red_out, result.red_out);
                check_field("green_out", want.green_out, result.green_out);
                check_field("blue_out", want.blue_out, result.blue_out);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hsl_colorize_pixel: mismatch");
            $finish;
        end
    end

    initial
    begin
        int          ph;
        int          n;
        logic [7:0]  g;
        int unsigned hv;
        int unsigned sv;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                if (ph < PLANNED)
                begin
                    write_reg(REG_HUE, DATA_W'(hue_plan[ph]));
                    write_reg(REG_SAT, DATA_W'(sat_plan[ph]));
                end
                else
                begin
                    hv = ($urandom_range(0, 7) == 0) ? $urandom_range(5760, 8191)
                                                     : $urandom_range(0, 5759);
                    sv = ($urandom_range(0, 7) == 0) ? $urandom_range(1025, 2047)
                                                     : $urandom_range(0, 1024);
                    write_reg(REG_HUE, ($urandom() & 32'hFFFF_E000) | hv);
                    write_reg(REG_SAT, ($urandom() & 32'hFFFF_F800) | sv);
                end
            end
            burst_mode = ($urandom_range(0, 3) == 0);
            if (ph == 1)
            begin
                queue_pixel(8'd0, 8'd0, 8'd0);
                queue_pixel(8'd255, 8'd255, 8'd255);
                queue_pixel(8'd255, 8'd0, 8'd0);
                queue_pixel(8'd0, 8'd255, 8'd0);
                queue_pixel(8'd0, 8'd0, 8'd255);
                queue_pixel(8'd128, 8'd128, 8'd128);
                queue_pixel(8'd255, 8'd0, 8'd128);
                queue_pixel(8'd127, 8'd0, 8'd0);
                queue_pixel(8'd200, 8'd100, 8'd50);
                queue_pixel(8'd1, 8'd254, 8'd0);
                queue_pixel(8'd255, 8'd255, 8'd0);
                queue_pixel(8'd0, 8'd255, 8'd255);
            end
            for (n = 0; n < PER_PHASE; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    g = rand_channel();
                    queue_pixel(g, g, g);
                end
                else
                    queue_pixel(rand_channel(), rand_channel(), rand_channel());
            end
            // hold off until every result of this phase is back
            while (colors_seen != pixels_queued)
                @(posedge clk);
        end
        repeat (12) @(posedge clk);
        if (error_count == 0 && expected_colors.size() == 0)
            $display("hsl_colorize_pixel: match");
        else
            $display("hsl_colorize_pixel: mismatch");
        $finish;
    end
endmodule
